### rtl/ssm_pkg.sv
// shared types and constants for the sorted sequence merger
`default_nettype none

package ssm_pkg;

   // sequence capacity and derived widths
   localparam int DEPTH  = 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int REM_W  = $clog2(2 * DEPTH + 1);
   localparam int KEY_W  = 32;

   // command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   // request mode codes
   localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
   localparam logic [1:0] MODE_RUN         = 2'd2;

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] merged_key;
      logic                    is_last;
      logic                    is_empty;
      logic                    overflowed;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_LOAD_FIRST,
      CMD_LOAD_SECOND,
      CMD_RUN
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic signed [KEY_W-1:0] key;
   } cmd_type;

   // head of the command queue as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } back_state_type;

endpackage

`default_nettype wire

### rtl/ssm_front.sv
// front end: takes transactions, classifies the mode and queues commands
`default_nettype none

module ssm_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire ssm_pkg::req_type       req_item,
   output logic                        busy,
   output ssm_pkg::queue_head_type     head,
   input  wire logic                   pop
);
   import ssm_pkg::*;

   cmd_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             cmd;
   logic                cmd_ok;
   logic                push;
   logic                do_pop;

   // classify the incoming mode, unknown mode is dropped
   always_comb begin
      cmd.key  = req_item.key;
      cmd.kind = CMD_RUN;
      cmd_ok   = 1'b1;
      case (req_item.mode)
         MODE_LOAD_FIRST:  cmd.kind = CMD_LOAD_FIRST;
         MODE_LOAD_SECOND: cmd.kind = CMD_LOAD_SECOND;
         MODE_RUN:         cmd.kind = CMD_RUN;
         default:          cmd_ok   = 1'b0;
      endcase
   end

   assign busy   = (count_ff == QCNT_W'(QDEPTH));
   assign push   = start && !busy && cmd_ok;
   assign do_pop = pop && (count_ff != '0);

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### rtl/ssm_back.sv
// back end: sequence stores, counts and the merge sequencer
`default_nettype none

module ssm_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ssm_pkg::queue_head_type head,
   output logic                        pop,
   output logic                        rsp_strobe,
   output ssm_pkg::rsp_type            rsp_item
);
   import ssm_pkg::*;

   logic [KEY_W-1:0]     first_mem  [DEPTH];
   logic [KEY_W-1:0]     second_mem [DEPTH];
   logic signed [KEY_W-1:0] first_rd_ff, second_rd_ff;

   back_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     n1_ff, n1_in, n2_ff, n2_in;
   logic [CNT_W-1:0]     i1_ff, i1_in, i2_ff, i2_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic                 dropped_ff, dropped_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 wr_first, wr_second;
   logic                 take_first;
   logic                 run_cmd;
   logic                 run_empty;

   assign pop       = (state_ff == ST_IDLE) && head.valid;
   assign run_cmd   = pop && (head.cmd.kind == CMD_RUN);
   assign run_empty = (n1_ff == '0) && (n2_ff == '0);
   assign take_first = (i1_ff < n1_ff) &&
                       ((i2_ff >= n2_ff) || (first_rd_ff < second_rd_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (run_cmd && !run_empty) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (rem_ff == REM_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      n1_in         = n1_ff;
      n2_in         = n2_ff;
      i1_in         = i1_ff;
      i2_in         = i2_ff;
      rem_in        = rem_ff;
      dropped_in    = dropped_ff;
      wr_first      = 1'b0;
      wr_second     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            i1_in = '0;
            i2_in = '0;
            if (pop) begin
               case (head.cmd.kind)
                  CMD_LOAD_FIRST: begin
                     if (n1_ff < CNT_W'(DEPTH)) begin
                        wr_first = 1'b1;
                        n1_in    = n1_ff + 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  CMD_LOAD_SECOND: begin
                     if (n2_ff < CNT_W'(DEPTH)) begin
                        wr_second = 1'b1;
                        n2_in     = n2_ff + 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  CMD_RUN: begin
                     rem_in = REM_W'(n1_ff) + REM_W'(n2_ff);
                     if (run_empty) begin
                        // both sequences empty: one marked result
                        rsp_strobe_in     = 1'b1;
                        rsp_in.merged_key = '0;
                        rsp_in.is_last    = 1'b1;
                        rsp_in.is_empty   = 1'b1;
                        rsp_in.overflowed = dropped_ff;
                        dropped_in        = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            // emit the smaller head, ties go to the second sequence
            rsp_strobe_in     = 1'b1;
            rsp_in.is_last    = (rem_ff == REM_W'(1));
            rsp_in.is_empty   = 1'b0;
            rsp_in.overflowed = dropped_ff;
            rem_in            = rem_ff - 1'b1;
            if (take_first) begin
               rsp_in.merged_key = first_rd_ff;
               i1_in             = i1_ff + 1'b1;
            end else begin
               rsp_in.merged_key = second_rd_ff;
               i2_in             = i2_ff + 1'b1;
            end
            if (rem_ff == REM_W'(1)) begin
               n1_in      = '0;
               n2_in      = '0;
               dropped_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         n1_ff         <= '0;
         n2_ff         <= '0;
         i1_ff         <= '0;
         i2_ff         <= '0;
         rem_ff        <= '0;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         n1_ff         <= n1_in;
         n2_ff         <= n2_in;
         i1_ff         <= i1_in;
         i2_ff         <= i2_in;
         rem_ff        <= rem_in;
         dropped_ff    <= dropped_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // sequence stores, read ahead at the next head index
   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_mem[n1_ff[ADDR_W-1:0]] <= head.cmd.key;
      end
      first_rd_ff <= first_mem[i1_in[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_second) begin
         second_mem[n2_ff[ADDR_W-1:0]] <= head.cmd.key;
      end
      second_rd_ff <= second_mem[i2_in[ADDR_W-1:0]];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // checks
   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> rem_ff != '0)
      else $error("merge running with nothing left");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> (i1_ff <= n1_ff) && (i2_ff <= n2_ff))
      else $error("merge index past its count");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.is_last |-> state_ff == ST_IDLE)
      else $error("last result while merge still running");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.is_empty |-> rsp_ff.is_last)
      else $error("empty result not marked last");

endmodule

`default_nettype wire

### rtl/sorted_sequence_merger_unit.sv
// top level of the two-way sorted sequence merger
//
//  channel   ports                        transaction taken when
//  request   start, busy, req_item        start high and busy low at the edge
//  result    rsp_strobe, rsp_item         every cycle with rsp_strobe high
//
// a load finishes in the back end as it is popped, so loads run one per cycle while no run is being merged.
// a run of n keys gives n results on consecutive cycles after the store read ports
// are primed; an empty run gives its single result at once.
// commands pass a two-entry queue; busy rises when it is full, which happens
// while the back end works through a run.
// reset is synchronous and clears counts, flags, queue and sequencer.
// results cannot be held off: each one is shown for a single cycle.
`default_nettype none

module sorted_sequence_merger_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire ssm_pkg::req_type   req_item,
   output logic                    busy,
   output logic                    rsp_strobe,
   output ssm_pkg::rsp_type        rsp_item
);
   import ssm_pkg::*;

   queue_head_type head;
   logic           pop;

   ssm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .head     (head),
      .pop      (pop)
   );

   ssm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

### test/tb_top.sv
// self-checking testbench for the two-way sorted sequence merger
`timescale 1ns / 1ps

module tb_top;
   import ssm_pkg::*;

   // mode 3 has no package code; the block ignores it
   localparam logic [1:0] MODE_IGNORED = 2'd3;
   localparam int KEY_MIN     = 32'sh8000_0000;
   localparam int KEY_MAX     = 32'sh7fff_ffff;
   localparam int STALL_LIMIT = 500;
   localparam int RANDOM_ITEMS = 250;

   typedef struct {
      req_type     item;
      int unsigned gap;
      bit          drain;
   } pending_cmd_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // stimulus and prediction state
   pending_cmd_type pending_cmds[$];
   rsp_type         merged_due[$];
   logic            results_drained = 1'b1;
   int              queued_count = 0;
   bit              bursty = 1'b1;
   bit              idle_off = 1'b0;
   int              mismatch_count = 0;

   logic signed [KEY_W-1:0] first_keys [DEPTH];
   logic signed [KEY_W-1:0] second_keys [DEPTH];
   int                      first_len = 0;
   int                      second_len = 0;
   bit                      drop_seen = 1'b0;

   sorted_sequence_merger_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #10 clock = ~clock;

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("mismatch: %s got %0h want %0h", what, got, want);
      mismatch_count++;
   endtask

   // expected results of one accepted command
   task automatic predict_merge(input req_type item);
      rsp_type r;
      int      i1;
      int      i2;
      int      total;
      case (item.mode)
         MODE_LOAD_FIRST: begin
            if (first_len < DEPTH) begin
               first_keys[first_len] = item.key;
               first_len++;
            end else begin
               drop_seen = 1'b1;
            end
         end
         MODE_LOAD_SECOND: begin
            if (second_len < DEPTH) begin
               second_keys[second_len] = item.key;
               second_len++;
            end else begin
               drop_seen = 1'b1;
            end
         end
         MODE_RUN: begin
            total = first_len + second_len;
            if (total == 0) begin
               r.merged_key = '0;
               r.is_last    = 1'b1;
               r.is_empty   = 1'b1;
               r.overflowed = drop_seen;
               merged_due.push_back(r);
            end else begin
               i1 = 0;
               i2 = 0;
               while (i1 < first_len || i2 < second_len) begin
                  // first head wins only when strictly less; ties go to second
                  if (i1 < first_len &&
                      (i2 >= second_len || first_keys[i1] < second_keys[i2])) begin
                     r.merged_key = first_keys[i1];
                     i1++;
                  end else begin
                     r.merged_key = second_keys[i2];
                     i2++;
                  end
                  r.is_last    = (i1 + i2 == total);
                  r.is_empty   = 1'b0;
                  r.overflowed = drop_seen;
                  merged_due.push_back(r);
               end
            end
            first_len  = 0;
            second_len = 0;
            drop_seen  = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic queue_cmd(input logic [1:0] mode, input int key, input bit drain);
      pending_cmd_type c;
      c.item.mode = mode;
      c.item.key  = key;
      c.drain     = drain;
      c.gap       = 0;
      if (!idle_off && bursty && $urandom_range(0, 3) == 0)
         c.gap = $urandom_range(1, 17);
      // a drain needs the expectation of the previous command to be visible
      if (drain && c.gap < 2)
         c.gap = 2;
      pending_cmds.push_back(c);
      queued_count++;
   endtask

   // two sequences loaded in random interleaving, then a run
   task automatic queue_merge_set(input int n_first, input int n_second, input bit drain_first);
      int keys [2][40];
      int cnt [2];
      int taken [2];
      int style;
      int s;
      int i;
      int j;
      int tmp;
      bit pause_next;
      cnt[0]   = n_first;
      cnt[1]   = n_second;
      taken[0] = 0;
      taken[1] = 0;
      style    = $urandom_range(0, 3);
      for (s = 0; s < 2; s++) begin
         for (i = 0; i < cnt[s]; i++) begin
            case (style)
               1: keys[s][i] = int'($urandom_range(0, 9)) - 5;
               2: begin
                  case ($urandom_range(0, 4))
                     0: keys[s][i] = KEY_MIN;
                     1: keys[s][i] = KEY_MAX;
                     2: keys[s][i] = -1;
                     3: keys[s][i] = 0;
                     default: keys[s][i] = 1;
                  endcase
               end
               default: keys[s][i] = $urandom;
            endcase
         end
         // mostly ascending; now and then left unsorted
         if ($urandom_range(0, 9) != 0) begin
            for (i = 1; i < cnt[s]; i++) begin
               tmp = keys[s][i];
               j = i - 1;
               while (j >= 0 && keys[s][j] > tmp) begin
                  keys[s][j + 1] = keys[s][j];
                  j--;
               end
               keys[s][j + 1] = tmp;
            end
         end
      end
      pause_next = drain_first;
      while (taken[0] < cnt[0] || taken[1] < cnt[1]) begin
         if (taken[0] < cnt[0] && (taken[1] >= cnt[1] || $urandom_range(0, 1) == 0))
            s = 0;
         else
            s = 1;
         queue_cmd((s == 0) ? MODE_LOAD_FIRST : MODE_LOAD_SECOND, keys[s][taken[s]],
                   pause_next);
         pause_next = 1'b0;
         taken[s]++;
         if ($urandom_range(0, 40) == 0)
            queue_cmd(MODE_IGNORED, $urandom, 1'b0);
      end
      queue_cmd(MODE_RUN, $urandom, pause_next);
   endtask

   // driver: presents pending commands, honoring gaps and drain points
   int unsigned gap_left = 0;
   bit          gap_done = 1'b0;

   always @(posedge clock) begin
      bit launch;
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
         gap_left = 0;
         gap_done = 1'b0;
      end else if (!(start && busy)) begin
         launch = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending_cmds.size() != 0) begin
            if (pending_cmds[0].gap != 0 && !gap_done) begin
               gap_left = pending_cmds[0].gap - 1;
               gap_done = 1'b1;
            end else if (!pending_cmds[0].drain || results_drained) begin
               launch = 1'b1;
            end
         end
         if (launch) begin
            req_item <= pending_cmds[0].item;
            void'(pending_cmds.pop_front());
            gap_done = 1'b0;
         end
         start <= launch;
      end
   end

   // monitor: predicts accepted commands, checks results, runs the watchdog
   int stall_cycles = 0;
   int result_no = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy)
            predict_merge(req_item);
         if (rsp_strobe) begin
            if (merged_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected result %0d key", result_no),
                             rsp_item.merged_key, 0);
            end else begin
               want = merged_due.pop_front();
               if (rsp_item.merged_key !== want.merged_key)
                  flag_mismatch($sformatf("result %0d merged_key", result_no),
                                rsp_item.merged_key, want.merged_key);
               if (rsp_item.is_last !== want.is_last)
                  flag_mismatch($sformatf("result %0d is_last", result_no),
                                rsp_item.is_last, want.is_last);
               if (rsp_item.is_empty !== want.is_empty)
                  flag_mismatch($sformatf("result %0d is_empty", result_no),
                                rsp_item.is_empty, want.is_empty);
               if (rsp_item.overflowed !== want.overflowed)
                  flag_mismatch($sformatf("result %0d overflowed", result_no),
                                rsp_item.overflowed, want.overflowed);
            end
            result_no++;
         end
         if ((start && !busy) || rsp_strobe)
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
      results_drained <= (merged_due.size() == 0);
   end

   // stimulus, reset and end of run
   initial begin
      int n1;
      int n2;
      int set_no;
      int random_target;
      int tail_mark;

      // directed: empty run, extremes, ties, single-sided and unsorted sets
      queue_cmd(MODE_RUN, 0, 1'b0);
      queue_cmd(MODE_IGNORED, -1, 1'b0);
      queue_cmd(MODE_LOAD_FIRST, KEY_MIN, 1'b0);
      queue_cmd(MODE_LOAD_SECOND, -1, 1'b0);
      queue_cmd(MODE_LOAD_FIRST, -1, 1'b0);
      queue_cmd(MODE_LOAD_SECOND, 5, 1'b0);
      queue_cmd(MODE_LOAD_FIRST, 5, 1'b0);
      queue_cmd(MODE_IGNORED, KEY_MAX, 1'b0);
      queue_cmd(MODE_LOAD_SECOND, KEY_MAX, 1'b0);
      queue_cmd(MODE_RUN, KEY_MAX, 1'b0);
      queue_cmd(MODE_RUN, KEY_MIN, 1'b1);
      queue_cmd(MODE_LOAD_FIRST, 7, 1'b0);
      queue_cmd(MODE_RUN, 0, 1'b0);
      queue_cmd(MODE_LOAD_SECOND, KEY_MAX, 1'b0);
      queue_cmd(MODE_RUN, 0, 1'b0);
      queue_cmd(MODE_LOAD_FIRST, 9, 1'b0);
      queue_cmd(MODE_LOAD_FIRST, 3, 1'b0);
      queue_cmd(MODE_LOAD_SECOND, 4, 1'b0);
      queue_cmd(MODE_RUN, 0, 1'b0);

      // random sets: mostly short, some full and overflowing
      random_target = queued_count + RANDOM_ITEMS;
      tail_mark     = queued_count + (RANDOM_ITEMS * 4) / 5;
      set_no        = 0;
      while (queued_count < random_target) begin
         if (queued_count > tail_mark)
            idle_off = 1'b1;
         bursty = ($urandom_range(0, 2) != 0);
         case (set_no)
            2: begin n1 = DEPTH; n2 = DEPTH; end
            5: begin n1 = DEPTH + 3; n2 = 3; end
            8: begin n1 = 1; n2 = DEPTH + 2; end
            11: begin n1 = 0; n2 = 0; end
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  n1 = $urandom_range(0, DEPTH);
                  n2 = $urandom_range(0, DEPTH);
               end else begin
                  n1 = $urandom_range(0, 6);
                  n2 = $urandom_range(0, 6);
               end
            end
         endcase
         queue_merge_set(n1, n2, !idle_off && (set_no == 4 || $urandom_range(0, 5) == 0));
         // run again straight away on empty sequences
         if ($urandom_range(0, 15) == 0)
            queue_cmd(MODE_RUN, $urandom, 1'b0);
         set_no++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || start || merged_due.size() != 0)
         @(negedge clock);
      repeat (16) @(posedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
